[rtl/lphs_pkg.sv]
// Package for the linear probe hash set: widths, codes, types.
package lphs_pkg;

    localparam int SLOTS_DEF = 16;
    localparam int CFG_W     = 5;
    localparam int OP_W      = 2;
    localparam int KEY_W     = 8;
    localparam int HASH_W    = 16;
    localparam int STAT_W    = 3;
    localparam int IDX_W     = 4;
    localparam int TOT_W     = 5;
    localparam int MARK_W    = 2;

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(10);

    // remainder unit retires two dividend bits per cycle
    localparam int MOD_STEPS = HASH_W / 2;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0] OP_MEMBER = 2'd2;

    localparam logic [STAT_W-1:0] STAT_INSERTED   = 3'd0;
    localparam logic [STAT_W-1:0] STAT_PRESENT    = 3'd1;
    localparam logic [STAT_W-1:0] STAT_DELETED    = 3'd2;
    localparam logic [STAT_W-1:0] STAT_DEL_MISS   = 3'd3;
    localparam logic [STAT_W-1:0] STAT_MEMBER     = 3'd4;
    localparam logic [STAT_W-1:0] STAT_NOT_MEMBER = 3'd5;
    localparam logic [STAT_W-1:0] STAT_FULL       = 3'd6;
    localparam logic [STAT_W-1:0] STAT_IGNORED    = 3'd7;

    localparam logic [MARK_W-1:0] MARK_EMPTY   = 2'd0;
    localparam logic [MARK_W-1:0] MARK_LIVE    = 2'd1;
    localparam logic [MARK_W-1:0] MARK_DELETED = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_PROBE,
        S_FINISH,
        S_DONE
    } t_state;

    typedef struct packed {
        logic              start;
        logic [HASH_W-1:0] dividend;
        logic [CFG_W-1:0]  divisor;
    } t_mod_req;

    typedef struct packed {
        logic             done;
        logic [CFG_W-1:0] rem;
    } t_mod_res;

endpackage

[rtl/linear_probe_hash_set_top.sv]
// Top level of the linear probe hash set with tombstones.
// Hash set of byte keys held in one slot RAM ({mark, key} per slot) with a
// valid bit per slot, so reset leaves every slot empty at once. Each input
// beat carries opcode, key, the caller's hash and a hash-present flag; each
// one yields exactly one result beat with status, slot index and the live
// entry count. The active slot count n is the slot-count register clamped
// to 1..SLOTS. The block works on one beat at a time: it captures the beat,
// runs the remainder unit (hash mod n, two bits a cycle), then scans the slot
// RAM from the home slot, one read a cycle through the RAM's registered read
// port, over at most n slots, stopping early on a key hit; then comes a
// write-back state and a state that hands the result to the output register.
// Beats without a hash or with an unused opcode skip the remainder unit and
// the scan. The output register lets the next beat start while a result waits
// on o_out_valid.
// Write the slot-count register only while the block is idle.
module linear_probe_hash_set_top #(
    parameter int SLOTS = lphs_pkg::SLOTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [lphs_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [lphs_pkg::OP_W-1:0]     i_opcode,
    input  logic [lphs_pkg::KEY_W-1:0]    i_key,
    input  logic [lphs_pkg::HASH_W-1:0]   i_hash_value,
    input  logic                          i_hash_found,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [lphs_pkg::STAT_W-1:0]   o_status,
    output logic [lphs_pkg::IDX_W-1:0]    o_slot_index,
    output logic [lphs_pkg::TOT_W-1:0]    o_entry_total
);

    localparam int IW = $clog2(SLOTS);
    localparam int NW = lphs_pkg::CFG_W;
    // slot counter wide enough for both the RAM index and the slot count
    localparam int SW = (IW > NW) ? IW : NW;
    localparam int MW = lphs_pkg::MARK_W + lphs_pkg::KEY_W;

    lphs_pkg::t_state r_state, n_state;

    // configuration
    logic [NW-1:0] r_cfg;
    logic [NW-1:0] n_act;

    // current beat
    logic [lphs_pkg::OP_W-1:0]  r_op;
    logic [lphs_pkg::KEY_W-1:0] r_key;
    logic [NW-1:0]              r_n;

    // probe bookkeeping
    logic [SW-1:0] r_s, n_s;              // next slot to read
    logic [NW-1:0] r_issued, n_issued;
    logic          r_chk_valid, n_chk_valid;
    logic [SW-1:0] r_chk_addr, n_chk_addr; // slot of data coming back
    logic [NW-1:0] r_checked, n_checked;
    logic          r_hit, n_hit;
    logic [SW-1:0] r_hit_addr, n_hit_addr;
    logic          r_free, n_free;
    logic [SW-1:0] r_free_addr, n_free_addr;

    logic [SLOTS-1:0] r_vld;
    logic [lphs_pkg::TOT_W-1:0] r_live, n_live;

    // finished result waiting for the output register
    logic [lphs_pkg::STAT_W-1:0] r_res_stat, n_res_stat;
    logic [lphs_pkg::IDX_W-1:0]  r_res_idx, n_res_idx;

    logic                        r_out_valid;
    logic [lphs_pkg::STAT_W-1:0] r_out_stat;
    logic [lphs_pkg::IDX_W-1:0]  r_out_idx;
    logic [lphs_pkg::TOT_W-1:0]  r_out_tot;

    // control
    logic in_accept, ignore, load_out, issue, probe_end;
    logic ram_we;
    logic [IW-1:0] ram_waddr, ram_raddr;
    logic [MW-1:0] ram_wdata, ram_rdata;
    logic [lphs_pkg::MARK_W-1:0] chk_mark;
    logic chk_match;
    logic [SW-1:0] s_wrap;

    lphs_pkg::t_mod_req mod_req;
    lphs_pkg::t_mod_res mod_res;

    lphs_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mod_req),
        .o_res   (mod_res)
    );

    lphs_ram #(
        .WIDTH (MW),
        .DEPTH (SLOTS)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // clamp the slot count to 1..SLOTS
    always_comb begin
        if (r_cfg == '0) begin
            n_act = NW'(1);
        end else if (32'(r_cfg) > SLOTS) begin
            n_act = NW'(SLOTS);
        end else begin
            n_act = r_cfg;
        end
    end

    assign in_accept = i_in_valid && !o_in_stall;
    assign ignore    = !i_hash_found || (i_opcode != lphs_pkg::OP_INSERT &&
                       i_opcode != lphs_pkg::OP_DELETE && i_opcode != lphs_pkg::OP_MEMBER);
    assign load_out  = (r_state == lphs_pkg::S_DONE) && (!r_out_valid || !i_out_stall);

    // returning slot data; a never-written slot reads as empty
    assign chk_mark  = r_vld[r_chk_addr[IW-1:0]] ? ram_rdata[lphs_pkg::KEY_W +: lphs_pkg::MARK_W]
                                                 : lphs_pkg::MARK_EMPTY;
    assign chk_match = (chk_mark == lphs_pkg::MARK_LIVE) &&
                       (ram_rdata[lphs_pkg::KEY_W-1:0] == r_key);
    assign probe_end = r_chk_valid && (chk_match || (NW'(r_checked + 1'b1) == r_n));
    assign issue     = (r_state == lphs_pkg::S_PROBE) && (r_issued != r_n) && !probe_end;
    assign s_wrap    = (SW'(r_s + 1'b1) == SW'(r_n)) ? '0 : SW'(r_s + 1'b1);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lphs_pkg::S_IDLE: begin
                if (in_accept) begin
                    n_state = ignore ? lphs_pkg::S_DONE : lphs_pkg::S_MOD;
                end
            end
            lphs_pkg::S_MOD: begin
                if (mod_res.done) begin
                    n_state = lphs_pkg::S_PROBE;
                end
            end
            lphs_pkg::S_PROBE: begin
                if (probe_end) begin
                    n_state = lphs_pkg::S_FINISH;
                end
            end
            lphs_pkg::S_FINISH: n_state = lphs_pkg::S_DONE;
            lphs_pkg::S_DONE: begin
                if (load_out) begin
                    n_state = lphs_pkg::S_IDLE;
                end
            end
            default: n_state = lphs_pkg::S_IDLE;
        endcase
    end

    // state outputs: handshake, remainder start, RAM ports
    always_comb begin
        o_in_stall       = (r_state != lphs_pkg::S_IDLE);
        mod_req.start    = (r_state == lphs_pkg::S_IDLE) && in_accept && !ignore;
        mod_req.dividend = i_hash_value;
        mod_req.divisor  = n_act;
        ram_raddr        = r_s[IW-1:0];
        ram_we           = 1'b0;
        ram_waddr        = r_hit_addr[IW-1:0];
        ram_wdata        = {lphs_pkg::MARK_DELETED, r_key};
        if (r_state == lphs_pkg::S_FINISH) begin
            if (r_op == lphs_pkg::OP_INSERT) begin
                ram_we    = !r_hit && r_free;
                ram_waddr = r_free_addr[IW-1:0];
                ram_wdata = {lphs_pkg::MARK_LIVE, r_key};
            end else if (r_op == lphs_pkg::OP_DELETE) begin
                ram_we    = r_hit;
            end
        end
    end

    // datapath next values
    always_comb begin
        n_s         = r_s;
        n_issued    = r_issued;
        n_chk_valid = 1'b0;
        n_chk_addr  = r_s;
        n_checked   = r_checked;
        n_hit       = r_hit;
        n_hit_addr  = r_hit_addr;
        n_free      = r_free;
        n_free_addr = r_free_addr;
        n_live      = r_live;
        n_res_stat  = r_res_stat;
        n_res_idx   = r_res_idx;

        unique case (r_state)
            lphs_pkg::S_IDLE: begin
                n_res_stat = lphs_pkg::STAT_IGNORED;
                n_res_idx  = '0;
            end
            lphs_pkg::S_MOD: begin
                n_s       = SW'(mod_res.rem);
                n_issued  = '0;
                n_checked = '0;
                n_hit     = 1'b0;
                n_free    = 1'b0;
            end
            lphs_pkg::S_PROBE: begin
                if (issue) begin
                    n_s         = s_wrap;
                    n_issued    = NW'(r_issued + 1'b1);
                    n_chk_valid = 1'b1;
                end
                if (r_chk_valid) begin
                    n_checked = NW'(r_checked + 1'b1);
                    if (chk_match) begin
                        n_hit      = 1'b1;
                        n_hit_addr = r_chk_addr;
                    end
                    if (chk_mark != lphs_pkg::MARK_LIVE && !r_free) begin
                        n_free      = 1'b1;
                        n_free_addr = r_chk_addr;
                    end
                end
            end
            lphs_pkg::S_FINISH: begin
                n_res_idx = '0;
                priority if (r_op == lphs_pkg::OP_INSERT) begin
                    if (r_hit) begin
                        n_res_stat = lphs_pkg::STAT_PRESENT;
                        n_res_idx  = r_hit_addr[lphs_pkg::IDX_W-1:0];
                    end else if (r_free) begin
                        n_res_stat = lphs_pkg::STAT_INSERTED;
                        n_res_idx  = r_free_addr[lphs_pkg::IDX_W-1:0];
                        n_live     = lphs_pkg::TOT_W'(r_live + 1'b1);
                    end else begin
                        n_res_stat = lphs_pkg::STAT_FULL;
                    end
                end else if (r_op == lphs_pkg::OP_DELETE) begin
                    if (r_hit) begin
                        n_res_stat = lphs_pkg::STAT_DELETED;
                        n_res_idx  = r_hit_addr[lphs_pkg::IDX_W-1:0];
                        if (r_live != '0) begin
                            n_live = lphs_pkg::TOT_W'(r_live - 1'b1);
                        end
                    end else begin
                        n_res_stat = lphs_pkg::STAT_DEL_MISS;
                    end
                end else begin
                    n_res_stat = r_hit ? lphs_pkg::STAT_MEMBER : lphs_pkg::STAT_NOT_MEMBER;
                    if (r_hit) begin
                        n_res_idx = r_hit_addr[lphs_pkg::IDX_W-1:0];
                    end
                end
            end
            lphs_pkg::S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lphs_pkg::S_IDLE;
            r_cfg       <= lphs_pkg::CFG_RESET;
            r_vld       <= '0;
            r_live      <= '0;
            r_chk_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_live      <= n_live;
            r_chk_valid <= n_chk_valid;
            if (i_cfg_we) begin
                r_cfg <= i_cfg_data;
            end
            if (ram_we) begin
                r_vld[ram_waddr] <= 1'b1;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (mod_req.start) begin
            r_op  <= i_opcode;
            r_key <= i_key;
            r_n   <= n_act;
        end
        r_s         <= n_s;
        r_issued    <= n_issued;
        r_chk_addr  <= n_chk_addr;
        r_checked   <= n_checked;
        r_hit       <= n_hit;
        r_hit_addr  <= n_hit_addr;
        r_free      <= n_free;
        r_free_addr <= n_free_addr;
        r_res_stat  <= n_res_stat;
        r_res_idx   <= n_res_idx;
        if (load_out) begin
            r_out_stat <= r_res_stat;
            r_out_idx  <= r_res_idx;
            r_out_tot  <= r_live;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_stat;
    assign o_slot_index  = r_out_idx;
    assign o_entry_total = r_out_tot;

    // a beat that needs probing always goes through the remainder unit
    a_start_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lphs_pkg::S_IDLE && in_accept && !ignore) |=> (r_state == lphs_pkg::S_MOD))
        else $error("probing beat did not start the remainder unit");

    // remainder result only arrives while waiting for it
    a_mod_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mod_res.done |-> (r_state == lphs_pkg::S_MOD))
        else $error("remainder done outside the remainder state");

    // live count only moves on write-back
    a_live_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_live) |-> ($past(r_state) == lphs_pkg::S_FINISH))
        else $error("live count changed outside write-back");

    // slot RAM is written only at write-back, and then to a probed slot
    a_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == lphs_pkg::S_FINISH && SW'(ram_waddr) < SW'(r_n)))
        else $error("slot write outside write-back or beyond active slots");

endmodule

[rtl/lphs_ram.sv]
// Generic single-clock RAM, one write port, one registered read port.
module lphs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/lphs_mod.sv]
// Iterative remainder unit: hash modulo slot count, two bits per cycle.
module lphs_mod (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lphs_pkg::t_mod_req i_req,
    output lphs_pkg::t_mod_res o_res
);

    localparam int CW = (lphs_pkg::MOD_STEPS > 1) ? $clog2(lphs_pkg::MOD_STEPS) : 1;
    localparam int RW = lphs_pkg::CFG_W;

    logic                          r_busy;
    logic [CW-1:0]                 r_cnt;
    logic [lphs_pkg::HASH_W-1:0]   r_q;
    logic [RW-1:0]                 r_d;
    logic [RW-1:0]                 r_rem;

    logic [RW:0]   t1, t2, d_ext;
    logic [RW-1:0] rem1, rem2;
    logic          last;

    always_comb begin
        d_ext = {1'b0, r_d};
        t1    = {r_rem, r_q[lphs_pkg::HASH_W-1]};
        rem1  = (t1 >= d_ext) ? RW'(t1 - d_ext) : t1[RW-1:0];
        t2    = {rem1, r_q[lphs_pkg::HASH_W-2]};
        rem2  = (t2 >= d_ext) ? RW'(t2 - d_ext) : t2[RW-1:0];
    end

    assign last = (r_cnt == CW'(lphs_pkg::MOD_STEPS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= CW'(r_cnt + 1'b1);
            if (last) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_q   <= i_req.dividend;
            r_d   <= i_req.divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_q   <= {r_q[lphs_pkg::HASH_W-3:0], 2'b00};
            r_rem <= rem2;
        end
    end

    assign o_res.done = r_busy && last;
    assign o_res.rem  = rem2;

endmodule
